@@ hw/rtl/bni_pkg.sv @@
// Shared constants, types and codes for the batch normalization block.
package bni_pkg;

    localparam int DATA_W           = 16;   // Q8.8 data fields
    localparam int CH_OUT_W         = 6;    // channel / entry index fields
    localparam int CNT_CFG_W        = 7;    // channel_count register
    localparam int CFG_IDX_W        = 2;
    localparam int SUM_W            = DATA_W + 1;   // variance + epsilon
    localparam int MAG_W            = DATA_W;       // operand magnitudes
    localparam int PROD_W           = 2 * MAG_W;    // |gain * (x - mean)|

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int FRAC_BITS_DEF    = 8;

    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic        [DATA_W-1:0]   udata_t;
    typedef logic        [CH_OUT_W-1:0] chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_EPSILON       = 2'd1,
        CFG_GAIN          = 2'd2,
        CFG_BIAS          = 2'd3
    } cfg_idx_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    localparam udata_t RESET_CHANNEL_COUNT = 16'd1;
    localparam udata_t RESET_EPSILON       = 16'd1;
    localparam udata_t RESET_GAIN          = 16'd256;
    localparam udata_t RESET_BIAS          = 16'd0;

    localparam udata_t SAT_POS = 16'h7FFF;
    localparam udata_t SAT_NEG = 16'h8000;

endpackage

@@ hw/rtl/bni_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
interface bni_req_if;
    import bni_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    data_t  sample;
    logic   first_of_tensor;
    chan_t  entry_index;
    data_t  entry_mean;
    udata_t entry_variance;

    modport source (
        output valid, req_type, sample, first_of_tensor,
               entry_index, entry_mean, entry_variance,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample, first_of_tensor,
               entry_index, entry_mean, entry_variance,
        output ready
    );
endinterface

interface bni_rsp_if;
    import bni_pkg::*;

    logic  valid;
    logic  ready;
    data_t result;
    chan_t channel;
    logic  saturated;
    logic  zero_denominator;

    modport source (
        output valid, result, channel, saturated, zero_denominator,
        input  ready
    );
    modport sink (
        input  valid, result, channel, saturated, zero_denominator,
        output ready
    );
endinterface

@@ hw/rtl/batch_norm_inference.sv @@
// Inference batch normalization engine, Q8.8, bit-serial datapath.
// Usage:
//   req  : valid/ready request stream. req_type = load writes mean and
//          variance of channel entry_index into the channel table (no
//          response). req_type = sample normalizes one element
//          of a channel-innermost tensor and yields exactly one response.
//   rsp  : valid/ready response stream (result, channel, saturated,
//          zero_denominator), held in an output register.
//   cfg  : cfg_we/cfg_index/cfg_data write port for channel_count,
//          variance_epsilon, gain, bias; write only while idle.
// Timing:
//   A sample transaction runs a 16-step shift-add multiplier beside the
//   two-bits-per-cycle root, then a 32-step restoring divider (skipped
//   when the root is zero). One sample in flight; req becomes ready in
//   the same cycle that the registered response turns valid. Loads are
//   accepted back to back while idle.
// Reset: config registers take their defaults, channel position goes to 0;
//   the table holds garbage until loaded.
// Stall: a result waits in the finish state while rsp is held; nothing is
//   accepted until the output slot frees.
module batch_norm_inference #(
    parameter int MAX_CHANNELS = bni_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = bni_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bni_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bni_pkg::DATA_W-1:0]     cfg_data,
    bni_req_if.sink                        req,
    bni_rsp_if.source                      rsp
);
    import bni_pkg::*;

    localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW        = (CH_W > CH_OUT_W) ? CH_W : CH_OUT_W;
    localparam int POS_W     = (CH_W + 1 > CNT_CFG_W) ? CH_W + 1 : CNT_CFG_W;
    localparam int RAD_RAW   = SUM_W + FRAC_BITS;
    localparam int RAD_W     = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int MUL_STEPS = MAG_W;
    localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
    localparam int Y_W       = PROD_W + 2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,   // table data in hand, launch root and multiply
        S_ITER   = 5'b00100,   // multiply and root stepping
        S_DIV    = 5'b01000,   // quotient bits
        S_FINISH = 5'b10000    // bias, clamp, hand to output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CNT_CFG_W-1:0] chan_count_reg;
    udata_t               eps_reg;
    udata_t               gain_reg;
    udata_t               bias_reg;

    // channel position
    logic [CH_W-1:0]  pos_reg, pos_next;
    logic [CH_W-1:0]  ch_sel;
    logic [POS_W-1:0] ch_wide;
    logic [POS_W-1:0] next_wide;

    // table
    logic [2*DATA_W-1:0] table_mem [MAX_CHANNELS];
    logic [2*DATA_W-1:0] rd_reg;
    logic [AW:0]         idx_ext;
    logic                idx_ok;

    logic acc, smp_acc, load_acc;

    // sample context
    udata_t            sample_reg;
    chan_t             chan_reg;
    logic              neg_reg,  neg_next;
    logic              zden_reg, zden_next;

    // serial multiplier: {partial sum, remaining multiplier bits}
    logic [PROD_W-1:0] mul_reg,  mul_next;
    logic [MCNT_W-1:0] mcnt_reg, mcnt_next;
    udata_t            mcand_reg, mcand_next;
    logic [MAG_W:0]    mul_add;

    // setup arithmetic
    udata_t            mean_v, var_v;
    logic [SUM_W-1:0]  var_sum;
    logic [RAD_W-1:0]  radicand;
    logic [MAG_W:0]    diff;
    logic [MAG_W:0]    diff_abs;
    udata_t            gain_abs;

    // root and divider units
    logic              sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] root;
    logic              div_start, div_done;
    logic [PROD_W-1:0] quot;
    logic              iter_done;

    // finish
    logic [Y_W-1:0]    bias_ext, q_ext, y;
    logic              y_over, y_under, mag_zero;
    udata_t            res_fin;
    logic              sat_fin;
    logic              fin_fire;

    // output register
    logic              out_valid_reg, out_valid_next;
    udata_t            res_reg;
    chan_t             chan_out_reg;
    logic              sat_reg;
    logic              zden_out_reg;

    // ---------------- request side ----------------
    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign smp_acc   = acc && (req.req_type == REQ_SAMPLE);
    assign load_acc  = acc && (req.req_type == REQ_LOAD);

    // first_of_tensor restarts the position before it is used
    assign ch_sel    = req.first_of_tensor ? '0 : pos_reg;
    assign ch_wide   = POS_W'(ch_sel);
    assign next_wide = ch_wide + 1'b1;

    always_comb
    begin
        pos_next = pos_reg;
        if (smp_acc)
        begin
            if (next_wide >= POS_W'(chan_count_reg) || next_wide >= POS_W'(MAX_CHANNELS))
                pos_next = '0;
            else
                pos_next = next_wide[CH_W-1:0];
        end
    end

    // loads beyond the table are dropped
    assign idx_ext = (AW+1)'(req.entry_index);
    assign idx_ok  = (idx_ext < (AW+1)'(MAX_CHANNELS));

    always_ff @(posedge clk)
    begin
        if (load_acc && idx_ok)
            table_mem[idx_ext[CH_W-1:0]] <= {req.entry_mean, req.entry_variance};
        if (smp_acc)
            rd_reg <= table_mem[ch_sel];
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            sample_reg <= req.sample;
            chan_reg   <= ch_wide[CH_OUT_W-1:0];
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= RESET_CHANNEL_COUNT[CNT_CFG_W-1:0];
            eps_reg        <= RESET_EPSILON;
            gain_reg       <= RESET_GAIN;
            bias_reg       <= RESET_BIAS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[CNT_CFG_W-1:0];
                CFG_EPSILON:       eps_reg        <= cfg_data;
                CFG_GAIN:          gain_reg       <= cfg_data;
                CFG_BIAS:          bias_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- setup arithmetic ----------------
    assign mean_v   = rd_reg[2*DATA_W-1:DATA_W];
    assign var_v    = rd_reg[DATA_W-1:0];
    assign var_sum  = SUM_W'(var_v) + SUM_W'(eps_reg);
    assign radicand = RAD_W'(var_sum) << FRAC_BITS;

    // numerator handled as sign and magnitude
    assign diff     = {sample_reg[DATA_W-1], sample_reg} - {mean_v[DATA_W-1], mean_v};
    assign diff_abs = diff[MAG_W] ? (~diff + 1'b1) : diff;
    assign gain_abs = gain_reg[DATA_W-1] ? (~gain_reg + 1'b1) : gain_reg;

    assign mul_add  = {1'b0, mul_reg[PROD_W-1:MAG_W]}
                    + (mul_reg[0] ? {1'b0, mcand_reg} : '0);

    assign sqrt_start = (state_reg == S_SETUP);
    assign iter_done  = (mcnt_reg == MCNT_W'(MUL_STEPS)) && sqrt_done;
    assign div_start  = (state_reg == S_ITER) && iter_done && (root != '0);

    bni_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    bni_div #(
        .NUM_W (PROD_W),
        .DEN_W (ROOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg),
        .divisor  (root),
        .done     (div_done),
        .quotient (quot)
    );

    // ---------------- finish: bias and clamp ----------------
    assign bias_ext = {{(Y_W-DATA_W){bias_reg[DATA_W-1]}}, bias_reg};
    assign q_ext    = Y_W'(quot);
    assign y        = neg_reg ? (bias_ext - q_ext) : (bias_ext + q_ext);
    assign y_over   = !y[Y_W-1] && (y[Y_W-2:DATA_W-1] != '0);
    assign y_under  =  y[Y_W-1] && (y[Y_W-2:DATA_W-1] != '1);
    assign mag_zero = (mul_reg == '0);

    always_comb
    begin
        if (zden_reg)
        begin
            // no root: sign of the numerator picks the rail, bias not added
            res_fin = mag_zero ? '0 : (neg_reg ? SAT_NEG : SAT_POS);
            sat_fin = !mag_zero;
        end
        else if (y_over)
        begin
            res_fin = SAT_POS;
            sat_fin = 1'b1;
        end
        else if (y_under)
        begin
            res_fin = SAT_NEG;
            sat_fin = 1'b1;
        end
        else
        begin
            res_fin = y[DATA_W-1:0];
            sat_fin = 1'b0;
        end
    end

    assign fin_fire = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        mul_next   = mul_reg;
        mcnt_next  = mcnt_reg;
        mcand_next = mcand_reg;
        neg_next   = neg_reg;
        zden_next  = zden_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (smp_acc)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                mul_next   = {{MAG_W{1'b0}}, diff_abs[MAG_W-1:0]};
                mcand_next = gain_abs;
                mcnt_next  = '0;
                neg_next   = gain_reg[DATA_W-1] ^ diff[MAG_W];
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (mcnt_reg != MCNT_W'(MUL_STEPS))
                begin
                    mul_next  = {mul_add, mul_reg[MAG_W-1:1]};
                    mcnt_next = mcnt_reg + 1'b1;
                end
                else if (sqrt_done)
                begin
                    zden_next  = (root == '0);
                    state_next = (root == '0) ? S_FINISH : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (fin_fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_fire)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg   <= mul_next;
        mcand_reg <= mcand_next;
        neg_reg   <= neg_next;
        zden_reg  <= zden_next;
        if (fin_fire)
        begin
            res_reg      <= res_fin;
            chan_out_reg <= chan_reg;
            sat_reg      <= sat_fin;
            zden_out_reg <= zden_reg;
        end
    end

    // ---------------- response side ----------------
    assign rsp.valid            = out_valid_reg;
    assign rsp.result           = res_reg;
    assign rsp.channel          = chan_out_reg;
    assign rsp.saturated        = sat_reg;
    assign rsp.zero_denominator = zden_out_reg;

endmodule

@@ hw/rtl/bni_isqrt.sv @@
// Digit-serial integer square root, two radicand bits per cycle.
module bni_isqrt #(
    parameter int RAD_W = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);
    import bni_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [ROOT_W:0]   rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+2:0] rem_t;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    always_comb
    begin
        rem_t = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        diff  = rem_t - trial;
        ge    = (rem_t >= trial);

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;

        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hw/rtl/bni_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module bni_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    import bni_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg,    q_next;     // dividend out at top, quotient in at bottom
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rt;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rt   = {rem_reg, q_reg[NUM_W-1]};
        diff = rt - {1'b0, den_reg};
        ge   = (rt >= {1'b0, den_reg});

        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;

        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : rt[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
